@@ rtl/tmt_pkg.sv @@
// package: transaction types, command and status codes and default sizes of the timer table
`default_nettype none
package tmt_pkg;

	localparam int ACTIVE_DEPTH_DEF = 16;
	localparam int QUEUE_DEPTH_DEF  = 8;
	localparam int PERIOD_BITS_DEF  = 24;

	localparam logic [1:0] CMD_RUN   = 2'd0;
	localparam logic [1:0] CMD_SET   = 2'd1;
	localparam logic [1:0] CMD_STOP  = 2'd2;
	localparam logic [1:0] CMD_CLEAR = 2'd3;

	localparam logic [1:0] ST_DONE     = 2'd0;
	localparam logic [1:0] ST_UPDATED  = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [7:0]  key;
		logic [23:0] period_ms;
		logic        ms_elapsed;
	} req_t;

	typedef struct packed {
		logic       fired;
		logic [7:0] fired_key;
		logic       last;
		logic       running;
		logic [1:0] status;
	} rsp_t;

endpackage
`default_nettype wire

@@ rtl/tmt_ram.sv @@
// simple dual-port synchronous ram with registered read data
`default_nettype none
module tmt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

@@ rtl/periodic_timer_table_unit.sv @@
// top level: keyed periodic timer table walked through block memories
//
//  channel | handshake             | payload
//  req     | req_valid / req_ready | req (cmd, key, period_ms, ms_elapsed)
//  rsp     | rsp_valid / rsp_ready | rsp (fired, fired_key, last, running, status)
//
// set and stop scan the active table, one entry a cycle
// a run pass walks the active table and then the queue; it gives a single
//   response with no expiry, else one response per fired timer
// one request at a time; req_ready is high only between transactions
// reset clears the fill counts and clock flag; table contents stay undefined
// a stalled rsp holds the block in its output step until it is taken
`default_nettype none
module periodic_timer_table_unit
	import tmt_pkg::*;
#(
	parameter int ACTIVE_DEPTH = ACTIVE_DEPTH_DEF,
	parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
	parameter int PERIOD_BITS  = PERIOD_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_ready,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_ready,
	output rsp_t      rsp
);

	localparam int PB  = PERIOD_BITS;
	localparam int AW  = $clog2(ACTIVE_DEPTH);
	localparam int CW  = $clog2(ACTIVE_DEPTH + 1);
	localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCW = $clog2(QUEUE_DEPTH + 1);
	localparam int EW  = 8 + 2 * PB + 1;
	localparam int QW  = 8 + PB;

	typedef enum logic [2:0] {
		S_IDLE, S_SEARCH, S_WALK, S_APPEND, S_EMIT_RD, S_EMIT_OUT, S_RESP
	} state_t;

	state_t          state_q;
	logic [1:0]      cmd_q;
	logic [7:0]      key_q;
	logic [PB-1:0]   period_q;
	logic            tick_en_q;
	logic            clk_run_q;
	logic [CW-1:0]   a_used_q;
	logic [QCW-1:0]  q_used_q;
	logic [CW-1:0]   i_q;
	logic [CW-1:0]   w_q;
	logic [CW-1:0]   nf_q;
	logic [CW-1:0]   e_q;
	logic [QCW-1:0]  j_q;
	logic            rd_v_q;
	logic            qrd_v_q;
	logic [AW-1:0]   ridx_q;
	logic            ovf_q;
	logic [1:0]      status_q;
	logic            rsp_valid_q;
	rsp_t            rsp_q;

	logic [31:0]     period_ext;
	logic [EW-1:0]   a_rdata, a_wdata;
	logic [AW-1:0]   a_waddr;
	logic            a_we;
	logic [QW-1:0]   q_rdata, q_wdata;
	logic            q_we;
	logic [7:0]      f_rdata;
	logic            f_we;
	logic [7:0]      d_key;
	logic [PB-1:0]   d_cnt, d_per, walk_cnt, qd_per;
	logic            d_mark, expire, hit, scan_end, out_free, running;
	logic            rsp_load;

	assign period_ext = {8'd0, req.period_ms};
	assign d_mark = a_rdata[0];
	assign d_per  = a_rdata[PB:1];
	assign d_cnt  = a_rdata[2*PB:PB+1];
	assign d_key  = a_rdata[EW-1:2*PB+1];
	assign qd_per = q_rdata[PB-1:0];
	assign expire = tick_en_q && (d_cnt <= PB'(1));
	assign walk_cnt = !tick_en_q ? d_cnt : (expire ? d_per : d_cnt - PB'(1));
	assign hit = rd_v_q && (d_key == key_q);
	assign scan_end = !rd_v_q && (i_q == a_used_q);
	assign out_free = !rsp_valid_q || rsp_ready;
	assign running = (a_used_q != '0) || (q_used_q != '0);
	assign rsp_load = out_free && (state_q == S_EMIT_OUT || state_q == S_RESP);

	always_comb begin
		a_we    = 1'b0;
		a_waddr = ridx_q;
		a_wdata = {d_key, d_cnt, d_per, 1'b0};
		q_we    = 1'b0;
		f_we    = 1'b0;
		case (state_q)
			S_SEARCH: begin
				if (hit) begin
					a_we = 1'b1;
					a_wdata = (cmd_q == CMD_SET) ? {d_key, d_cnt, period_q, 1'b0}
						: {d_key, d_cnt, d_per, 1'b1};
				end else if (scan_end && cmd_q == CMD_SET && q_used_q < QCW'(QUEUE_DEPTH)) begin
					q_we = 1'b1;
				end
			end
			S_WALK: begin
				a_waddr = w_q[AW-1:0];
				a_wdata = {d_key, walk_cnt, d_per, 1'b0};
				a_we = rd_v_q && !d_mark;
				f_we = rd_v_q && !d_mark && expire;
			end
			S_APPEND: begin
				a_waddr = a_used_q[AW-1:0];
				a_wdata = {q_rdata[QW-1:PB], qd_per, qd_per, 1'b0};
				a_we = qrd_v_q && (a_used_q < CW'(ACTIVE_DEPTH));
			end
			default: begin
				a_we = 1'b0;
			end
		endcase
	end

	assign q_wdata = {key_q, period_q};

	tmt_ram #(.WIDTH(EW), .DEPTH(ACTIVE_DEPTH)) u_active (
		.clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
		.raddr(i_q[AW-1:0]), .rdata(a_rdata)
	);

	tmt_ram #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk(clk), .we(q_we), .waddr(q_used_q[QAW-1:0]), .wdata(q_wdata),
		.raddr(j_q[QAW-1:0]), .rdata(q_rdata)
	);

	tmt_ram #(.WIDTH(8), .DEPTH(ACTIVE_DEPTH)) u_fired (
		.clk(clk), .we(f_we), .waddr(nf_q[AW-1:0]), .wdata(d_key),
		.raddr(e_q[AW-1:0]), .rdata(f_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			clk_run_q   <= 1'b0;
			a_used_q    <= '0;
			q_used_q    <= '0;
			rd_v_q      <= 1'b0;
			qrd_v_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
			i_q         <= '0;
			j_q         <= '0;
			w_q         <= '0;
			nf_q        <= '0;
			e_q         <= '0;
			ovf_q       <= 1'b0;
			status_q    <= ST_DONE;
			tick_en_q   <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp_ready && !rsp_load) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						cmd_q    <= req.cmd;
						key_q    <= req.key;
						period_q <= period_ext[PB-1:0];
						i_q      <= '0;
						j_q      <= '0;
						w_q      <= '0;
						nf_q     <= '0;
						e_q      <= '0;
						rd_v_q   <= 1'b0;
						qrd_v_q  <= 1'b0;
						ovf_q    <= 1'b0;
						status_q <= ST_DONE;
						case (req.cmd)
							CMD_RUN: begin
								if (a_used_q == '0 && q_used_q == '0) begin
									clk_run_q <= 1'b0;
									state_q   <= S_RESP;
								end else begin
									clk_run_q <= 1'b1;
									tick_en_q <= clk_run_q && req.ms_elapsed;
									state_q   <= S_WALK;
								end
							end
							CMD_CLEAR: begin
								a_used_q <= '0;
								q_used_q <= '0;
								state_q  <= S_RESP;
							end
							default: begin
								state_q <= S_SEARCH;
							end
						endcase
					end
				end
				S_SEARCH: begin
					if (hit) begin
						status_q <= (cmd_q == CMD_SET) ? ST_UPDATED : ST_DONE;
						state_q  <= S_RESP;
					end else if (scan_end) begin
						if (cmd_q == CMD_STOP) begin
							status_q <= ST_NOT_FOUND;
						end else if (q_used_q < QCW'(QUEUE_DEPTH)) begin
							q_used_q <= q_used_q + QCW'(1);
						end else begin
							status_q <= ST_FULL;
						end
						state_q <= S_RESP;
					end else if (i_q < a_used_q) begin
						i_q    <= i_q + CW'(1);
						ridx_q <= i_q[AW-1:0];
						rd_v_q <= 1'b1;
					end else begin
						rd_v_q <= 1'b0;
					end
				end
				S_WALK: begin
					if (rd_v_q && !d_mark) begin
						w_q <= w_q + CW'(1);
						if (expire) begin
							nf_q <= nf_q + CW'(1);
						end
					end
					if (scan_end) begin
						a_used_q <= w_q;
						state_q  <= S_APPEND;
					end else if (i_q < a_used_q) begin
						i_q    <= i_q + CW'(1);
						rd_v_q <= 1'b1;
					end else begin
						rd_v_q <= 1'b0;
					end
				end
				S_APPEND: begin
					if (qrd_v_q) begin
						if (a_used_q < CW'(ACTIVE_DEPTH)) begin
							a_used_q <= a_used_q + CW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
					end
					if (!qrd_v_q && j_q == q_used_q) begin
						q_used_q <= '0;
						status_q <= ovf_q ? ST_FULL : ST_DONE;
						state_q  <= (nf_q == '0) ? S_RESP : S_EMIT_RD;
					end else if (j_q < q_used_q) begin
						j_q     <= j_q + QCW'(1);
						qrd_v_q <= 1'b1;
					end else begin
						qrd_v_q <= 1'b0;
					end
				end
				S_EMIT_RD: begin
					state_q <= S_EMIT_OUT;
				end
				S_EMIT_OUT: begin
					if (out_free) begin
						rsp_valid_q     <= 1'b1;
						rsp_q.fired     <= 1'b1;
						rsp_q.fired_key <= f_rdata;
						rsp_q.last      <= (e_q == nf_q - CW'(1));
						rsp_q.running   <= running;
						rsp_q.status    <= status_q;
						e_q             <= e_q + CW'(1);
						state_q <= (e_q == nf_q - CW'(1)) ? S_IDLE : S_EMIT_RD;
					end
				end
				S_RESP: begin
					if (out_free) begin
						rsp_valid_q     <= 1'b1;
						rsp_q.fired     <= 1'b0;
						rsp_q.fired_key <= 8'd0;
						rsp_q.last      <= 1'b1;
						rsp_q.running   <= running;
						rsp_q.status    <= status_q;
						state_q         <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_active_bound: assert property (@(posedge clk) disable iff (!arst_n)
		a_used_q <= CW'(ACTIVE_DEPTH))
		else $error("active count beyond table depth");

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_used_q <= QCW'(QUEUE_DEPTH))
		else $error("queue count beyond queue depth");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready && req.cmd == CMD_CLEAR) |=> (a_used_q == '0 && q_used_q == '0))
		else $error("clear left entries behind");

	a_fired_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK) |-> (nf_q <= w_q && w_q <= i_q))
		else $error("walk pointers out of order");

endmodule
`default_nettype wire
